### src/pgn_record_json_escaper_core_macros.svh
// Assertion macros used by the record escaper top level.
`ifndef PGN_RECORD_JSON_ESCAPER_CORE_MACROS_SVH
`define PGN_RECORD_JSON_ESCAPER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PJE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PJE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pje_pkg.sv
// Types and constants for the record escaper.
`timescale 1ns / 1ps

package pje_pkg;

    localparam int unsigned MAX_OUT = 6;
    localparam int unsigned CNT_W   = 3;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOS  = 1'b1;

    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;

    localparam logic [1:0] SPLIT_RUN = 2'd2;
    localparam logic [1:0] RUN_MAX   = 2'd3;

    typedef logic [MAX_OUT-1:0][7:0] byte_seq_t;

    typedef struct packed {
        byte_seq_t        seq;
        logic [CNT_W-1:0] cnt;
        logic [1:0]       newline_run;
        logic             string_open;
    } dec_out_t;

endpackage

### src/pje_decode.sv
// Expands one input item into its output byte sequence and next state.
`timescale 1ns / 1ps

module pje_decode
    import pje_pkg::*;
(
    input  logic       operation,
    input  logic [7:0] in_byte,
    input  logic [1:0] newline_run,
    input  logic       string_open,
    output dec_out_t   dec
);

    logic [7:0]       esc;
    logic [CNT_W-1:0] n;

    always_comb begin
        case (in_byte)
            CH_BACKSLASH: esc = CH_BACKSLASH;
            CH_QUOTE:     esc = CH_QUOTE;
            CH_BS:        esc = CH_B;
            CH_FF:        esc = CH_F;
            CH_LF:        esc = CH_N;
            CH_CR:        esc = CH_R;
            CH_TAB:       esc = CH_T;
            default:      esc = 8'h00;
        endcase
    end

    always_comb begin
        dec = '0;
        n   = '0;
        if (operation == OP_EOS) begin
            if (string_open) begin
                dec.seq[0] = CH_QUOTE;
                dec.seq[1] = CH_LF;
                n = CNT_W'(2);
            end
            dec.string_open = 1'b0;
            dec.newline_run = 2'd0;
        end else begin
            if (!string_open) begin
                dec.seq[n] = CH_QUOTE;
                n = n + 1'b1;
            end
            if (in_byte == CH_LBRACKET && newline_run == SPLIT_RUN) begin
                dec.seq[n] = CH_QUOTE;
                n = n + 1'b1;
                dec.seq[n] = CH_LF;
                n = n + 1'b1;
                dec.seq[n] = CH_QUOTE;
                n = n + 1'b1;
            end
            if (esc != 8'h00) begin
                dec.seq[n] = CH_BACKSLASH;
                n = n + 1'b1;
                dec.seq[n] = esc;
                n = n + 1'b1;
            end else begin
                dec.seq[n] = in_byte;
                n = n + 1'b1;
            end
            dec.string_open = 1'b1;
            if (in_byte == CH_LF) begin
                dec.newline_run = (newline_run == RUN_MAX) ? RUN_MAX
                                                           : newline_run + 2'd1;
            end else begin
                dec.newline_run = 2'd0;
            end
        end
        dec.cnt = n;
    end

endmodule

### src/pgn_record_json_escaper_core.sv
// Top level of the chess record to JSON string escaper.
//
// Input channel s_: one item per handshake, s_operation selects a data
// byte (s_in_byte) or end of stream. Result channel m_: one output byte
// per handshake, m_last marks the final byte caused by an input item.
// Each item expands to 0..4 output bytes; they are held in a small
// sequence register and sent one per cycle, so the output side sets the
// rate. The first output byte is presented in the cycle after input
// acceptance. A plain byte inside an open string sustains one item per
// cycle while m_ready is high; the next item is accepted in the same
// cycle as the previous item's last byte leaves. An end of stream with
// no string open yields nothing and leaves s_ready high.
// When m_ready is low the held byte stays on the port and s_ready drops.
// Synchronous active-low reset clears the newline run and the string-open
// flag and drops any held sequence.
`timescale 1ns / 1ps

`include "pgn_record_json_escaper_core_macros.svh"

module pgn_record_json_escaper_core
    import pje_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_operation,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last
);

    dec_out_t         dec;
    byte_seq_t        seq_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             valid_reg;
    logic [1:0]       newline_run_reg;
    logic             string_open_reg;
    logic             s_fire;
    logic             m_fire;

    pje_decode u_decode (
        .operation   (s_operation),
        .in_byte     (s_in_byte),
        .newline_run (newline_run_reg),
        .string_open (string_open_reg),
        .dec         (dec)
    );

    assign m_valid    = valid_reg;
    assign m_out_byte = seq_reg[idx_reg];
    assign m_last     = (idx_reg == cnt_reg - 1'b1);
    assign m_fire     = valid_reg && m_ready;
    assign s_ready    = !valid_reg || (m_ready && m_last);
    assign s_fire     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= 1'b0;
            idx_reg         <= '0;
            cnt_reg         <= '0;
            newline_run_reg <= 2'd0;
            string_open_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                newline_run_reg <= dec.newline_run;
                string_open_reg <= dec.string_open;
                valid_reg       <= (dec.cnt != '0);
                cnt_reg         <= dec.cnt;
                idx_reg         <= '0;
            end else if (m_fire) begin
                if (m_last) begin
                    valid_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            seq_reg <= dec.seq;
        end
    end

    `PJE_ASSERT_NEXT(a_data_yields_output, aclk, aresetn,
        s_fire && s_operation == OP_DATA, m_valid && string_open_reg,
        "data item produced no output or left string closed")
    `PJE_ASSERT_NOW(a_idx_in_range, aclk, aresetn,
        valid_reg, idx_reg < cnt_reg && cnt_reg <= CNT_W'(MAX_OUT),
        "sequence index out of range")
    `PJE_ASSERT_NOW(a_accept_only_at_end, aclk, aresetn,
        s_ready && valid_reg, m_ready && m_last,
        "input accepted while output sequence unfinished")
    `PJE_ASSERT_NEXT(a_eos_clears_state, aclk, aresetn,
        s_fire && s_operation == OP_EOS, !string_open_reg && newline_run_reg == 2'd0,
        "end of stream did not clear state")

endmodule
